FILE: src/rotor_cipher_three_wheel_top_defines.svh
// ---------------------------------------------------------------------------
// Rotor cipher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROTOR_CIPHER_THREE_WHEEL_TOP_DEFINES_SVH
`define ROTOR_CIPHER_THREE_WHEEL_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RC3W_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc3w assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RC3W_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc3w assertion failed");

`endif

FILE: src/rc3w_pkg.sv
// ---------------------------------------------------------------------------
// Rotor cipher package
// Types, wiring tables and mod-26 helpers shared by the rotor cipher block.
// ---------------------------------------------------------------------------
package rc3w_pkg;

    localparam int LETTER_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LETTER_W-1:0] NUM_LETTERS  = 5'd26;
    localparam logic [LETTER_W-1:0] LEFT_RESET   = 5'd7;
    localparam logic [LETTER_W-1:0] MIDDLE_RESET = 5'd3;
    localparam logic [LETTER_W-1:0] RIGHT_RESET  = 5'd22;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_MIDDLE = 2'd1,
        CFG_RIGHT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        letter_t left_pos;
        letter_t middle_pos;
    } rotor_cfg_t;

    typedef struct packed {
        letter_t letter;
        letter_t right_pos;
    } qitem_t;

    typedef struct packed {
        logic   valid;
        qitem_t item;
    } qpush_t;

    localparam letter_t WHEEL_LEFT [26] = '{
        5'd4,  5'd10, 5'd12, 5'd5,  5'd11, 5'd6,  5'd3,  5'd16, 5'd21, 5'd25,
        5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7,  5'd23, 5'd20, 5'd18, 5'd15,
        5'd0,  5'd8,  5'd1,  5'd17, 5'd2,  5'd9
    };

    localparam letter_t WHEEL_MIDDLE [26] = '{
        5'd0,  5'd9,  5'd3,  5'd10, 5'd18, 5'd8,  5'd17, 5'd20, 5'd23, 5'd1,
        5'd11, 5'd7,  5'd22, 5'd19, 5'd12, 5'd2,  5'd16, 5'd6,  5'd25, 5'd13,
        5'd15, 5'd24, 5'd5,  5'd21, 5'd14, 5'd4
    };

    localparam letter_t WHEEL_RIGHT [26] = '{
        5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19,
        5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,
        5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14
    };

    localparam letter_t REFLECTOR_B [26] = '{
        5'd24, 5'd17, 5'd20, 5'd7,  5'd16, 5'd18, 5'd11, 5'd3,  5'd15, 5'd23,
        5'd13, 5'd6,  5'd14, 5'd10, 5'd12, 5'd8,  5'd4,  5'd1,  5'd5,  5'd25,
        5'd2,  5'd22, 5'd21, 5'd9,  5'd0,  5'd19
    };

    localparam letter_t INV_LEFT [26] = '{
        5'd20, 5'd22, 5'd24, 5'd6,  5'd0,  5'd3,  5'd5,  5'd15, 5'd21, 5'd25,
        5'd1,  5'd4,  5'd2,  5'd10, 5'd12, 5'd19, 5'd7,  5'd23, 5'd18, 5'd11,
        5'd17, 5'd8,  5'd13, 5'd16, 5'd14, 5'd9
    };

    localparam letter_t INV_MIDDLE [26] = '{
        5'd0,  5'd9,  5'd15, 5'd2,  5'd25, 5'd22, 5'd17, 5'd11, 5'd5,  5'd1,
        5'd3,  5'd10, 5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6,  5'd4,  5'd13,
        5'd7,  5'd23, 5'd12, 5'd8,  5'd21, 5'd18
    };

    localparam letter_t INV_RIGHT [26] = '{
        5'd19, 5'd0,  5'd6,  5'd1,  5'd15, 5'd2,  5'd18, 5'd3,  5'd16, 5'd4,
        5'd20, 5'd5,  5'd21, 5'd13, 5'd25, 5'd7,  5'd24, 5'd8,  5'd23, 5'd9,
        5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12
    };

    // Reduces any 5-bit value to 0..25.
    function automatic letter_t mod26(letter_t v);
        return (v >= NUM_LETTERS) ? letter_t'(v - NUM_LETTERS) : v;
    endfunction

    // Both operands must already lie in 0..25.
    function automatic letter_t add26(letter_t a, letter_t b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, NUM_LETTERS}) ? letter_t'(s - {1'b0, NUM_LETTERS})
                                           : s[LETTER_W-1:0];
    endfunction

    // Both operands must already lie in 0..25.
    function automatic letter_t sub26(letter_t a, letter_t b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, NUM_LETTERS} - {1'b0, b};
        return (a >= b) ? letter_t'(a - b) : s[LETTER_W-1:0];
    endfunction

endpackage

FILE: src/rc3w_front.sv
// ---------------------------------------------------------------------------
// Rotor cipher front end
// Holds the configuration registers and the right rotor position, accepts
// items and queues each letter together with its stepped position.
// ---------------------------------------------------------------------------
module rc3w_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [rc3w_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  rc3w_pkg::letter_t                   cfg_data,
    input  logic                                in_valid,
    input  rc3w_pkg::letter_t                   letter_in,
    input  logic                                restart,
    input  logic                                queue_full,
    output logic                                in_stall,
    output rc3w_pkg::qpush_t                    push,
    output rc3w_pkg::rotor_cfg_t                rotor_cfg
);

    rc3w_pkg::letter_t left_start_reg;
    rc3w_pkg::letter_t middle_start_reg;
    rc3w_pkg::letter_t right_start_reg;
    rc3w_pkg::letter_t right_pos_reg;
    rc3w_pkg::letter_t right_pos_next;
    rc3w_pkg::letter_t right_base;
    logic              accept;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        right_base     = restart ? rc3w_pkg::mod26(right_start_reg) : right_pos_reg;
        right_pos_next = rc3w_pkg::add26(right_base, 5'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_start_reg   <= rc3w_pkg::LEFT_RESET;
            middle_start_reg <= rc3w_pkg::MIDDLE_RESET;
            right_start_reg  <= rc3w_pkg::RIGHT_RESET;
            right_pos_reg    <= rc3w_pkg::RIGHT_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    rc3w_pkg::CFG_LEFT:   left_start_reg   <= cfg_data;
                    rc3w_pkg::CFG_MIDDLE: middle_start_reg <= cfg_data;
                    rc3w_pkg::CFG_RIGHT:  right_start_reg  <= cfg_data;
                    default:              ;
                endcase
            end
            if (accept)
            begin
                right_pos_reg <= right_pos_next;
            end
        end
    end

    assign push.valid          = accept;
    assign push.item.letter    = rc3w_pkg::mod26(letter_in);
    assign push.item.right_pos = right_pos_next;

    assign rotor_cfg.left_pos   = rc3w_pkg::mod26(left_start_reg);
    assign rotor_cfg.middle_pos = rc3w_pkg::mod26(middle_start_reg);

endmodule

FILE: src/rc3w_queue.sv
// ---------------------------------------------------------------------------
// Rotor cipher item queue
// Small register FIFO that decouples the front end from the cipher path.
// ---------------------------------------------------------------------------
module rc3w_queue
#(
    parameter int WIDTH = $bits(rc3w_pkg::qitem_t),
    parameter int DEPTH = rc3w_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: src/rc3w_back.sv
// ---------------------------------------------------------------------------
// Rotor cipher back end
// Two-stage cipher path: forward rotors and reflector, then inverse rotors
// into the output register.
// ---------------------------------------------------------------------------
module rc3w_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rc3w_pkg::rotor_cfg_t   rotor_cfg,
    input  logic                   q_valid,
    input  rc3w_pkg::qitem_t       q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rc3w_pkg::letter_t      letter_out
);

    logic              s1_valid_reg;
    rc3w_pkg::letter_t s1_refl_reg;
    rc3w_pkg::letter_t s1_right_reg;
    logic              out_valid_reg;
    rc3w_pkg::letter_t out_letter_reg;
    logic              out_adv;
    logic              s1_adv;
    rc3w_pkg::letter_t fa;
    rc3w_pkg::letter_t fb;
    rc3w_pkg::letter_t fc;
    rc3w_pkg::letter_t fr;
    rc3w_pkg::letter_t bd;
    rc3w_pkg::letter_t be;
    rc3w_pkg::letter_t bf;

    assign out_adv = !out_valid_reg || !out_stall;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q_pop   = q_valid && s1_adv;

    always_comb
    begin
        fa = rc3w_pkg::WHEEL_RIGHT[rc3w_pkg::add26(q_item.right_pos, q_item.letter)];
        fb = rc3w_pkg::WHEEL_MIDDLE[rc3w_pkg::sub26(
                 rc3w_pkg::add26(rotor_cfg.middle_pos, fa), q_item.right_pos)];
        fc = rc3w_pkg::WHEEL_LEFT[rc3w_pkg::sub26(
                 rc3w_pkg::add26(rotor_cfg.left_pos, fb), rotor_cfg.middle_pos)];
        fr = rc3w_pkg::REFLECTOR_B[rc3w_pkg::sub26(fc, rotor_cfg.left_pos)];
    end

    always_comb
    begin
        bd = rc3w_pkg::sub26(
                 rc3w_pkg::INV_LEFT[rc3w_pkg::add26(s1_refl_reg, rotor_cfg.left_pos)],
                 rotor_cfg.left_pos);
        be = rc3w_pkg::sub26(
                 rc3w_pkg::INV_MIDDLE[rc3w_pkg::add26(bd, rotor_cfg.middle_pos)],
                 rotor_cfg.middle_pos);
        bf = rc3w_pkg::sub26(
                 rc3w_pkg::INV_RIGHT[rc3w_pkg::add26(be, s1_right_reg)],
                 s1_right_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_refl_reg  <= fr;
            s1_right_reg <= q_item.right_pos;
        end
        if (out_adv)
        begin
            out_letter_reg <= bf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign letter_out = out_letter_reg;

endmodule

FILE: src/rotor_cipher_three_wheel_top.sv
// ---------------------------------------------------------------------------
// Three-wheel rotor cipher
// Enciphers one letter per item through three fixed rotors and a reflector.
// ---------------------------------------------------------------------------
//  Channel  Handshake                Payload
//  cfg      cfg_valid / cfg_ready    cfg_index (2b), cfg_data (5b)
//  in       in_valid / in_stall      letter_in (5b), restart (1b)
//  out      out_valid / out_stall    letter_out (5b)
//
//  One item per cycle sustained while out_stall is low; an accepted item
//  passes through the queue and the first cipher stage before it reaches
//  the output register that drives out_valid.
//  Reset loads the start registers and the right position with H, D and W.
//  in_stall rises only when the item queue is full; out_stall holds the
//  output register and backs up the cipher stages and then the queue.
// ---------------------------------------------------------------------------
module rotor_cipher_three_wheel_top
#(
    parameter int QUEUE_DEPTH = rc3w_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc3w_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc3w_pkg::LETTER_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rc3w_pkg::LETTER_W-1:0]   letter_in,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rc3w_pkg::LETTER_W-1:0]   letter_out
);

    rc3w_pkg::qpush_t     push;
    rc3w_pkg::rotor_cfg_t rotor_cfg;
    rc3w_pkg::qitem_t     q_item;
    logic                 queue_full;
    logic                 q_valid;
    logic                 q_pop;

    assign cfg_ready = 1'b1;

    rc3w_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .letter_in  (letter_in),
        .restart    (restart),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .rotor_cfg  (rotor_cfg)
    );

    rc3w_queue
    #(
        .WIDTH ($bits(rc3w_pkg::qitem_t)),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push.valid),
        .push_data  (push.item),
        .full       (queue_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_item)
    );

    rc3w_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rotor_cfg  (rotor_cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .letter_out (letter_out)
    );

endmodule

FILE: src/rc3w_checker.sv
// ---------------------------------------------------------------------------
// Rotor cipher port checker
// Watches the top level ports for output stability, letter range and cfg_ready.
// ---------------------------------------------------------------------------
`include "rotor_cipher_three_wheel_top_defines.svh"

module rc3w_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [rc3w_pkg::LETTER_W-1:0]   letter_out
);

    `RC3W_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    `RC3W_ASSERT_NOW(a_out_range, out_valid, letter_out < rc3w_pkg::NUM_LETTERS)

    `RC3W_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(letter_out))

    `RC3W_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind rotor_cipher_three_wheel_top rc3w_checker u_rc3w_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the three-wheel rotor cipher
// A queued driver feeds letters with random restarts through the input
// channel while a monitor checks every enciphered letter against an
// in-bench rotor model. Register settings change between drained phases,
// and both channels idle at random, including a long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        rc3w_pkg::letter_t letter;
        logic              restart;
    } plain_item_t;

    localparam logic [rc3w_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int CHAR_A = 65;
    localparam int BURST_CYCLES = 80;

    localparam logic [8*26-1:0] WIRE_LEFT   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    localparam logic [8*26-1:0] WIRE_MIDDLE = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
    localparam logic [8*26-1:0] WIRE_RIGHT  = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    localparam logic [8*26-1:0] REFLECT_B   = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rc3w_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    rc3w_pkg::letter_t              cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    rc3w_pkg::letter_t              letter_in = '0;
    logic                           restart = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    rc3w_pkg::letter_t              letter_out;

    plain_item_t       pending_letters[$];
    rc3w_pkg::letter_t cipher_expect[$];
    plain_item_t       next_plain;
    rc3w_pkg::letter_t want_letter;

    rc3w_pkg::letter_t rotor_left = rc3w_pkg::LEFT_RESET;
    rc3w_pkg::letter_t rotor_mid = rc3w_pkg::MIDDLE_RESET;
    rc3w_pkg::letter_t rotor_right = rc3w_pkg::RIGHT_RESET;
    int                wheel_pos = 22;

    int error_count = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 67;
    int burst_trig = 0;
    int burst_seen = 0;
    int burst_left = 0;

    rotor_cipher_three_wheel_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .letter_in  (letter_in),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .letter_out (letter_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int wire_at(logic [8*26-1:0] wiring, int idx);
        return int'(wiring[8*(25 - idx % 26) +: 8]) - CHAR_A;
    endfunction

    function automatic int wire_find(logic [8*26-1:0] wiring, int val);
        int k;
        for (k = 0; k < 26; k++)
        begin
            if (wire_at(wiring, k) == val % 26)
                return k;
        end
        return 0;
    endfunction

    function automatic int diff26(int a, int b);
        return (a % 26 + 26 - b % 26) % 26;
    endfunction

    function automatic rc3w_pkg::letter_t encipher_letter(rc3w_pkg::letter_t plain,
                                                           logic reload);
        int l, m, r, a, b, c, q, d, e, f;
        l = int'(rotor_left) % 26;
        m = int'(rotor_mid) % 26;
        if (reload)
            wheel_pos = int'(rotor_right) % 26;
        wheel_pos = (wheel_pos + 1) % 26;
        r = wheel_pos;
        a = wire_at(WIRE_RIGHT, r + int'(plain));
        b = wire_at(WIRE_MIDDLE, diff26(m + a, r));
        c = wire_at(WIRE_LEFT, diff26(l + b, m));
        q = wire_at(REFLECT_B, diff26(c, l));
        d = diff26(wire_find(WIRE_LEFT, q + l), l);
        e = diff26(wire_find(WIRE_MIDDLE, d + m), m);
        f = diff26(wire_find(WIRE_RIGHT, e + r), r);
        return rc3w_pkg::letter_t'(f);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                cipher_expect.push_back(encipher_letter(letter_in, restart));
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else if (pending_letters.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_plain = pending_letters.pop_front();
                in_valid <= 1'b1;
                letter_in <= next_plain.letter;
                restart <= next_plain.restart;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (burst_trig != burst_seen)
        begin
            burst_seen <= burst_trig;
            burst_left <= BURST_CYCLES;
        end
        else if (burst_left != 0)
        begin
            burst_left <= burst_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_expect.size() == 0)
                begin
                    report_error($sformatf("letter_out %0d with no letter pending", letter_out));
                end
                else
                begin
                    want_letter = cipher_expect.pop_front();
                    if (letter_out !== want_letter)
                        report_error($sformatf("letter_out %0d, expected %0d",
                                               letter_out, want_letter));
                end
            end
            out_stall <= (burst_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic write_register(input logic [rc3w_pkg::CFG_IDX_W-1:0] idx,
                                  input rc3w_pkg::letter_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rc3w_pkg::CFG_LEFT:   rotor_left = val;
            rc3w_pkg::CFG_MIDDLE: rotor_mid = val;
            rc3w_pkg::CFG_RIGHT:  rotor_right = val;
            default:              ;
        endcase
    endtask

    task automatic queue_letter(input int letter, input logic reload);
        plain_item_t item;
        item.letter = rc3w_pkg::letter_t'(letter);
        item.restart = reload;
        pending_letters.push_back(item);
    endtask

    task automatic queue_random(input int count);
        int k;
        int letter;
        for (k = 0; k < count; k++)
        begin
            letter = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 31)
                                                 : $urandom_range(0, 25);
            queue_letter(letter, $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_letters.size() != 0 || in_valid || cipher_expect.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        queue_letter(0, 1'b0);
        queue_letter(25, 1'b0);
        queue_letter(31, 1'b0);
        queue_letter(26, 1'b0);
        queue_letter(0, 1'b1);
        queue_letter(0, 1'b0);
        queue_letter(25, 1'b1);
        queue_letter(30, 1'b1);
        queue_letter(21, 1'b0);
        queue_letter(10, 1'b0);
        queue_letter(5, 1'b1);
        queue_letter(16, 1'b0);
        queue_letter(27, 1'b0);
        queue_letter(28, 1'b0);
        queue_letter(29, 1'b1);
        queue_letter(15, 1'b0);
        queue_letter(1, 1'b0);
        queue_letter(2, 1'b0);
        queue_letter(4, 1'b0);
        queue_letter(8, 1'b0);
        wait_drained();

        write_register(rc3w_pkg::CFG_LEFT, 5'd0);
        write_register(rc3w_pkg::CFG_MIDDLE, 5'd0);
        write_register(rc3w_pkg::CFG_RIGHT, 5'd0);
        write_register(CFG_NONE, 5'd31);
        send_idle_pct = 11;
        recv_idle_pct = 67;
        queue_letter(0, 1'b1);
        queue_random(400);
        wait_drained();

        write_register(rc3w_pkg::CFG_LEFT, 5'd25);
        write_register(rc3w_pkg::CFG_MIDDLE, 5'd25);
        write_register(rc3w_pkg::CFG_RIGHT, 5'd25);
        send_idle_pct = 67;
        recv_idle_pct = 11;
        queue_letter(25, 1'b1);
        queue_random(120);
        wait_drained();

        write_register(rc3w_pkg::CFG_RIGHT, 5'd31);
        queue_random(10);
        queue_letter(7, 1'b1);
        queue_random(110);
        wait_drained();

        write_register(rc3w_pkg::CFG_LEFT, 5'd31);
        write_register(rc3w_pkg::CFG_MIDDLE, 5'd26);
        write_register(rc3w_pkg::CFG_RIGHT, 5'd27);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        burst_trig <= burst_trig + 1;
        queue_letter(3, 1'b1);
        queue_random(40);
        wait_drained();

        write_register(rc3w_pkg::CFG_LEFT, rc3w_pkg::letter_t'($urandom_range(0, 31)));
        write_register(rc3w_pkg::CFG_MIDDLE, rc3w_pkg::letter_t'($urandom_range(0, 31)));
        write_register(rc3w_pkg::CFG_RIGHT, rc3w_pkg::letter_t'($urandom_range(0, 31)));
        queue_random(100);
        wait_drained();
        repeat (10) @(posedge clk);

        if (cipher_expect.size() != 0)
            report_error($sformatf("%0d letters never came out", cipher_expect.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
